@@ sv/sha_pkg.sv @@
`default_nettype none
package sha_pkg;

    localparam int unsigned WordW = 32;

    typedef logic [WordW-1:0] t_word;

    // front -> back queue entry
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_beat;

    localparam int unsigned QDepth = 4;
    localparam int unsigned QAw = 2;

    localparam logic [255:0] InitHash = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic t_word round_k(input logic [5:0] t);
        t_word k;
        unique case (t)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (WordW - n));
    endfunction

endpackage
`default_nettype wire

@@ sv/sha_front.sv @@
`default_nettype none
// intake queue: accepts beats, drops idle beats, holds the rest for the core
module sha_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    output logic             o_full,
    input  sha_pkg::t_beat   i_beat,
    output logic             o_valid,
    output sha_pkg::t_beat   o_beat,
    input  wire              i_take
);
    sha_pkg::t_beat r_q [sha_pkg::QDepth];
    logic [sha_pkg::QAw-1:0] r_wr, r_rd;
    logic [sha_pkg::QAw:0]   r_cnt, n_cnt;
    logic wr, rd;

    assign o_full  = (r_cnt == sha_pkg::QAw'(0) + (sha_pkg::QAw+1)'(sha_pkg::QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_beat  = r_q[r_rd];
    assign wr = i_push && !o_full && (i_beat.has_byte || i_beat.end_of_message);
    assign rd = i_take && o_valid;

    always_comb begin
        n_cnt = r_cnt + (sha_pkg::QAw+1)'(wr) - (sha_pkg::QAw+1)'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (wr) r_wr <= r_wr + 1'b1;
            if (rd) r_rd <= r_rd + 1'b1;
        end
        if (wr) r_q[r_wr] <= i_beat;
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (sha_pkg::QAw+1)'(sha_pkg::QDepth)) else $error("queue overflow");
    a_full_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !wr) else $error("write while full");
    a_rd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd |-> r_cnt != '0) else $error("read while empty");
endmodule
`default_nettype wire

@@ sv/sha_core.sv @@
`default_nettype none
// block buffer, round engine and digest output register
module sha_core (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  sha_pkg::t_beat   i_beat,
    output logic             o_take,
    output logic             o_empty,
    input  wire              i_pop,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);
    localparam logic [2:0] S_IN = 3'd0, S_RND = 3'd1, S_ADD = 3'd2,
                           S_PAD = 3'd3, S_OUT = 3'd4;

    logic [2:0]  r_st;
    logic [511:0] r_blk;        // big-endian block, byte 0 at top
    logic [5:0]  r_fill;
    logic [60:0] r_cnt;
    logic [255:0] r_h;
    sha_pkg::t_word r_v [8];
    sha_pkg::t_word r_w [16];
    logic [5:0]  r_t;
    logic        r_pad;         // padding phase active
    logic        r_fin;         // this block carries the length
    logic [2:0]  r_oi;

    sha_pkg::t_word w, s0, s1, ch, mj, t1, t2, g0, g1;
    logic [511:0] padb;
    logic [63:0] bits;

    assign o_take = (r_st == S_IN) && i_valid;
    assign o_empty = (r_st != S_OUT);
    assign o_digest_word = r_h[255 - 32*r_oi -: 32];
    assign o_word_index = r_oi;
    assign o_last_word = (r_oi == 3'd7);

    always_comb begin
        g0 = sha_pkg::rotr(r_w[1], 7) ^ sha_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        g1 = sha_pkg::rotr(r_w[14], 17) ^ sha_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w  = r_w[0];
        s1 = sha_pkg::rotr(r_v[4], 6) ^ sha_pkg::rotr(r_v[4], 11) ^ sha_pkg::rotr(r_v[4], 25);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1 = r_v[7] + s1 + ch + sha_pkg::round_k(r_t) + w;
        s0 = sha_pkg::rotr(r_v[0], 2) ^ sha_pkg::rotr(r_v[0], 13) ^ sha_pkg::rotr(r_v[0], 22);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2 = s0 + mj;
        bits = {r_cnt, 3'b000};
        padb = r_blk;
        for (int i = 0; i < 64; i++) begin
            if (6'(i) == r_fill && !r_pad) padb[511-8*i -: 8] = 8'h80;
            else if (6'(i) > r_fill || (6'(i) == r_fill && r_pad)) padb[511-8*i -: 8] = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IN;
            r_fill <= '0;
            r_cnt <= '0;
            r_h <= sha_pkg::InitHash;
            r_pad <= 1'b0;
            r_fin <= 1'b0;
            r_oi <= '0;
            r_t <= '0;
        end else begin
            unique case (r_st)
                S_IN: if (i_valid) begin
                    if (i_beat.has_byte) begin
                        r_blk[511 - 8*r_fill -: 8] <= i_beat.data_byte;
                        r_cnt <= r_cnt + 61'd1;
                        r_fill <= r_fill + 6'd1;
                    end
                    if (i_beat.has_byte && r_fill == 6'd63) begin
                        r_pad <= 1'b0;
                        r_fin <= 1'b0;
                        if (i_beat.end_of_message) r_oi <= 3'd1;  // length block follows
                        r_st <= S_PAD;
                    end else if (i_beat.end_of_message) begin
                        r_pad <= 1'b0;
                        r_fin <= 1'b1;
                        r_st <= S_PAD;
                    end
                end
                S_PAD: begin
                    // load schedule; pad when finishing
                    r_t <= '0;
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[255-32*i -: 32];
                    if (!r_fin) begin
                        for (int i = 0; i < 16; i++) r_w[i] <= r_blk[511-32*i -: 32];
                    end else begin
                        if (!r_pad && r_fill > 6'd55) begin
                            for (int i = 0; i < 16; i++) r_w[i] <= padb[511-32*i -: 32];
                            r_pad <= 1'b1;
                            r_fill <= '0;
                            r_fin <= 1'b0;
                            r_oi <= 3'd1;   // marks extra block pending
                        end else begin
                            for (int i = 0; i < 14; i++) r_w[i] <= padb[511-32*i -: 32];
                            r_w[14] <= bits[63:32];
                            r_w[15] <= bits[31:0];
                        end
                    end
                    r_st <= S_RND;
                end
                S_RND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= r_w[0] + g0 + r_w[9] + g1;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_t <= r_t + 6'd1;
                    if (r_t == 6'd63) r_st <= S_ADD;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++)
                        r_h[255-32*i -: 32] <= r_h[255-32*i -: 32] + r_v[i];
                    if (r_oi == 3'd1) begin
                        r_oi <= '0;
                        r_fin <= 1'b1;
                        r_st <= S_PAD;
                    end else if (r_fin) begin
                        r_oi <= '0;
                        r_st <= S_OUT;
                    end else begin
                        r_st <= S_IN;
                    end
                end
                S_OUT: if (i_pop) begin
                    r_oi <= r_oi + 3'd1;
                    if (r_oi == 3'd7) begin
                        r_h <= sha_pkg::InitHash;
                        r_cnt <= '0;
                        r_fill <= '0;
                        r_pad <= 1'b0;
                        r_fin <= 1'b0;
                        r_st <= S_IN;
                    end
                end
                default: r_st <= S_IN;
            endcase
        end
    end

    a_take_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> r_st == S_IN) else $error("take outside intake");
    a_out_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT && i_pop && r_oi == 3'd7) |=> r_st == S_IN) else $error("digest end");
    a_rnd_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_RND && r_t == 6'd63) |=> r_st == S_ADD) else $error("round count");
endmodule
`default_nettype wire

@@ sv/sha256_stream_hasher.sv @@
`default_nettype none
// SHA-256 over a byte stream. Beats enter a 4-deep queue at one per cycle while
// it has room; idle beats are dropped there. The core takes one byte per cycle
// into its block buffer; each full block then passes through load, 64 rounds
// in one shared round unit and chain add, during which intake stalls. An
// end-of-message beat pads, runs one or two blocks, then presents the eight
// digest words in order, one per pop.
module sha256_stream_hasher (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         push,
    output logic        full,
    input  wire [7:0]   i_data_byte,
    input  wire         i_has_byte,
    input  wire         i_end_of_message,
    output logic        empty,
    input  wire         pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    sha_pkg::t_beat beat_in, beat_q;
    logic q_valid, q_take;

    assign beat_in.data_byte = i_data_byte;
    assign beat_in.has_byte = i_has_byte;
    assign beat_in.end_of_message = i_end_of_message;

    sha_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_beat(beat_in), .o_valid(q_valid), .o_beat(beat_q), .i_take(q_take));

    sha_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_beat(beat_q),
        .o_take(q_take), .o_empty(empty), .i_pop(pop),
        .o_digest_word(o_digest_word), .o_word_index(o_word_index),
        .o_last_word(o_last_word));
endmodule
`default_nettype wire
